>>> rtl/core/gda_pkg.sv
package gda_pkg;

    // calendar date as held inside the unit
    typedef struct packed {
        logic [15:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
    } t_date;

    // serial day accumulator, days since 0001-01-01
    localparam int ACC_W = 25;
    typedef logic [ACC_W-1:0] t_acc;

    // operation codes
    localparam logic [2:0] FN_NEXT_DAY    = 3'd0;
    localparam logic [2:0] FN_NEXT_MONTH  = 3'd1;
    localparam logic [2:0] FN_NEXT_YEAR   = 3'd2;
    localparam logic [2:0] FN_DAY_COUNT   = 3'd3;
    localparam logic [2:0] FN_WEEKDAY     = 3'd4;
    localparam logic [2:0] FN_NEXT_MONDAY = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SER0,
        S_SER1,
        S_SER2,
        S_SER3,
        S_MON,
        S_DAY,
        S_MOD7,
        S_STEP,
        S_CALC,
        S_DONE
    } t_state;

    // x / 25 by reciprocal, exact for x below 16384
    function automatic logic [9:0] div25(input logic [13:0] x);
        logic [26:0] pr;
        pr = 27'(x) * 27'd5243;
        return pr[26:17];
    endfunction

    function automatic logic is_leap(input logic [15:0] y);
        logic [9:0]  q2;
        logic [9:0]  q4;
        logic [13:0] b2;
        logic [13:0] b4;
        logic        m100;
        logic        m400;
        q2   = div25(y[15:2]);
        q4   = div25({2'b00, y[15:4]});
        b2   = 14'(q2) * 14'd25;
        b4   = 14'(q4) * 14'd25;
        m100 = (b2 == y[15:2]);
        m400 = (y[3:0] == 4'd0) && (b4 == {2'b00, y[15:4]});
        return (y[1:0] == 2'b00) && (!m100 || m400);
    endfunction

    function automatic logic [4:0] month_len(input logic [15:0] y, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = is_leap(y) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // value mod 7, folding octal digits since 8 is 1 mod 7
    function automatic logic [2:0] mod7(input t_acc v);
        logic [26:0] w;
        logic [5:0]  s;
        logic [3:0]  t;
        logic [2:0]  u;
        w = 27'(v);
        s = 6'd0;
        for (int k = 0; k < 9; k++) begin
            s = s + 6'(w[3*k +: 3]);
        end
        t = 4'(s[5:3]) + 4'(s[2:0]);
        u = 3'(4'(t[3]) + 4'(t[2:0]));
        return (u == 3'd7) ? 3'd0 : u;
    endfunction

endpackage

>>> rtl/core/gda_date_clamp.sv
module gda_date_clamp #(
    parameter int MAX_YEAR = 9999
) (
    input  logic [13:0]         i_year,
    input  logic [3:0]          i_month,
    input  logic [4:0]          i_day,
    output gda_pkg::t_date      o_date
);

    localparam logic [15:0] MaxY = 16'(MAX_YEAR);

    logic [15:0] c_y;
    logic [3:0]  c_m;
    logic [4:0]  c_len;

    // pull year and month into range
    always_comb begin
        c_y = 16'(i_year);
        if (c_y == 16'd0) begin
            c_y = 16'd1;
        end
        if (c_y > MaxY) begin
            c_y = MaxY;
        end
        c_m = i_month;
        if (c_m == 4'd0) begin
            c_m = 4'd1;
        end
        if (c_m > 4'd12) begin
            c_m = 4'd12;
        end
    end

    // day clamped into 1 .. month length
    always_comb begin
        c_len    = gda_pkg::month_len(c_y, c_m);
        o_date.y = c_y;
        o_date.m = c_m;
        o_date.d = i_day;
        if (i_day == 5'd0) begin
            o_date.d = 5'd1;
        end
        if (i_day > c_len) begin
            o_date.d = c_len;
        end
    end

endmodule

>>> rtl/core/gregorian_date_arithmetic.sv
// channel   direction  handshake               payload
// request   in         i_valid / o_stall       i_func, i_year_a..i_day_a, i_year_b..i_day_b
// result    out        o_valid / i_stall       o_res_year, o_res_month, o_res_day,
//                                              o_day_count, o_weekday
//
// one request at a time, held in S_DONE until the output register is free
// day count, weekday and next monday use the serial-day accumulator, which walks
// one month length per cycle through a single adder
// synchronous active-low reset clears the sequencer and the result valid
// a finished result waits in the output register while the next request is taken
module gregorian_date_arithmetic #(
    parameter int MAX_YEAR = 9999
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic [13:0]        i_year_a,
    input  logic [3:0]         i_month_a,
    input  logic [4:0]         i_day_a,
    input  logic [13:0]        i_year_b,
    input  logic [3:0]         i_month_b,
    input  logic [4:0]         i_day_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [13:0]        o_res_year,
    output logic [3:0]         o_res_month,
    output logic [4:0]         o_res_day,
    output logic signed [22:0] o_day_count,
    output logic [2:0]         o_weekday
);

    localparam logic [15:0] MaxY = 16'(MAX_YEAR);

    gda_pkg::t_state r_state, n_state;
    logic            r_o_valid, n_o_valid;

    logic [2:0]      r_func;
    logic [13:0]     r_ya, r_yb;
    logic [3:0]      r_ma, r_mb;
    logic [4:0]      r_da, r_db;
    logic [15:0]     r_y, n_y;
    logic [3:0]      r_m, n_m;
    logic [4:0]      r_d, n_d;
    logic [3:0]      r_i, n_i;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_second, n_second;
    gda_pkg::t_acc   r_acc, n_acc;
    gda_pkg::t_acc   r_ser_a, n_ser_a;
    logic [22:0]     r_count, n_count;
    logic [2:0]      r_wd, n_wd;
    logic [13:0]     r_oy, n_oy;
    logic [3:0]      r_om, n_om;
    logic [4:0]      r_od, n_od;
    logic [22:0]     r_oc, n_oc;
    logic [2:0]      r_ow, n_ow;

    logic [13:0]     c_sy;
    logic [3:0]      c_sm;
    logic [4:0]      c_sd;
    gda_pkg::t_date  c_date;
    logic [15:0]     c_p;
    gda_pkg::t_acc   c_term;
    logic            c_sub;
    gda_pkg::t_acc   c_sum;
    logic [4:0]      c_len;
    logic            c_accept;
    logic            c_has_date;

    assign o_stall  = (r_state != gda_pkg::S_IDLE);
    assign c_accept = i_valid && !o_stall;

    // clamp source: date b while switching over for the day count
    assign c_sy = (r_state == gda_pkg::S_DAY) ? r_yb : r_ya;
    assign c_sm = (r_state == gda_pkg::S_DAY) ? r_mb : r_ma;
    assign c_sd = (r_state == gda_pkg::S_DAY) ? r_db : r_da;

    gda_date_clamp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_clamp (
        .i_year  (c_sy),
        .i_month (c_sm),
        .i_day   (c_sd),
        .o_date  (c_date)
    );

    // shared accumulator adder, term picked by the sequencer
    assign c_p   = r_y - 16'd1;
    assign c_len = gda_pkg::month_len(r_y, r_m);
    always_comb begin
        c_sub  = 1'b0;
        c_term = '0;
        case (r_state)
            gda_pkg::S_SER1: begin
                c_term = gda_pkg::t_acc'(c_p[15:2]);
            end
            gda_pkg::S_SER2: begin
                c_term = gda_pkg::t_acc'(gda_pkg::div25(c_p[15:2]));
                c_sub  = 1'b1;
            end
            gda_pkg::S_SER3: begin
                c_term = gda_pkg::t_acc'(gda_pkg::div25({2'b00, c_p[15:4]}));
            end
            gda_pkg::S_MON: begin
                c_term = gda_pkg::t_acc'(gda_pkg::month_len(r_y, r_i));
            end
            gda_pkg::S_DAY: begin
                c_term = gda_pkg::t_acc'(r_d - 5'd1);
            end
            default: begin
                c_term = '0;
            end
        endcase
        c_sum = c_sub ? (r_acc - c_term) : (r_acc + c_term);
    end

    assign c_has_date = (r_func == gda_pkg::FN_NEXT_DAY) || (r_func == gda_pkg::FN_NEXT_MONTH)
                     || (r_func == gda_pkg::FN_NEXT_YEAR)
                     || (r_func == gda_pkg::FN_NEXT_MONDAY);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_o_valid = r_o_valid;
        n_y      = r_y;
        n_m      = r_m;
        n_d      = r_d;
        n_i      = r_i;
        n_cnt    = r_cnt;
        n_second = r_second;
        n_acc    = r_acc;
        n_ser_a  = r_ser_a;
        n_count  = r_count;
        n_wd     = r_wd;
        n_oy     = r_oy;
        n_om     = r_om;
        n_od     = r_od;
        n_oc     = r_oc;
        n_ow     = r_ow;
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            gda_pkg::S_IDLE: begin
                if (c_accept) begin
                    n_state = gda_pkg::S_LOAD;
                end
            end
            gda_pkg::S_LOAD: begin
                n_y      = c_date.y;
                n_m      = c_date.m;
                n_d      = c_date.d;
                n_second = 1'b0;
                n_cnt    = 3'd1;
                n_count  = '0;
                n_wd     = '0;
                case (r_func)
                    gda_pkg::FN_NEXT_DAY: begin
                        n_state = gda_pkg::S_STEP;
                    end
                    gda_pkg::FN_NEXT_MONTH, gda_pkg::FN_NEXT_YEAR: begin
                        n_state = gda_pkg::S_CALC;
                    end
                    gda_pkg::FN_DAY_COUNT, gda_pkg::FN_WEEKDAY,
                    gda_pkg::FN_NEXT_MONDAY: begin
                        n_state = gda_pkg::S_SER0;
                    end
                    default: begin
                        n_state = gda_pkg::S_DONE;
                    end
                endcase
            end
            gda_pkg::S_SER0: begin
                n_acc   = gda_pkg::t_acc'(c_p) * gda_pkg::t_acc'(365);
                n_i     = 4'd1;
                n_state = gda_pkg::S_SER1;
            end
            gda_pkg::S_SER1: begin
                n_acc   = c_sum;
                n_state = gda_pkg::S_SER2;
            end
            gda_pkg::S_SER2: begin
                n_acc   = c_sum;
                n_state = gda_pkg::S_SER3;
            end
            gda_pkg::S_SER3: begin
                n_acc   = c_sum;
                n_state = gda_pkg::S_MON;
            end
            gda_pkg::S_MON: begin
                // one month length per cycle
                if (r_i == r_m) begin
                    n_state = gda_pkg::S_DAY;
                end else begin
                    n_acc = c_sum;
                    n_i   = r_i + 4'd1;
                end
            end
            gda_pkg::S_DAY: begin
                n_acc = c_sum;
                if (r_func == gda_pkg::FN_DAY_COUNT) begin
                    if (!r_second) begin
                        n_ser_a  = c_sum;
                        n_second = 1'b1;
                        n_y      = c_date.y;
                        n_m      = c_date.m;
                        n_d      = c_date.d;
                        n_state  = gda_pkg::S_SER0;
                    end else begin
                        n_count = 23'(c_sum - r_ser_a);
                        n_state = gda_pkg::S_DONE;
                    end
                end else begin
                    n_state = gda_pkg::S_MOD7;
                end
            end
            gda_pkg::S_MOD7: begin
                // epoch 1900-01-01 serial is a multiple of 7
                n_wd  = gda_pkg::mod7(r_acc);
                n_cnt = 3'd7 - gda_pkg::mod7(r_acc);
                if (r_func == gda_pkg::FN_NEXT_MONDAY) begin
                    n_state = gda_pkg::S_STEP;
                end else begin
                    n_state = gda_pkg::S_DONE;
                end
            end
            gda_pkg::S_STEP: begin
                // next day, holding at the last date
                if (r_d < c_len) begin
                    n_d = r_d + 5'd1;
                end else if (r_m < 4'd12) begin
                    n_m = r_m + 4'd1;
                    n_d = 5'd1;
                end else if (r_y < MaxY) begin
                    n_y = r_y + 16'd1;
                    n_m = 4'd1;
                    n_d = 5'd1;
                end
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    n_state = gda_pkg::S_DONE;
                end
            end
            gda_pkg::S_CALC: begin
                if (r_func == gda_pkg::FN_NEXT_MONTH) begin
                    if (r_m == 4'd12) begin
                        if (r_y >= MaxY) begin
                            n_y = MaxY;
                            n_d = 5'd31;
                        end else begin
                            n_y = r_y + 16'd1;
                            n_m = 4'd1;
                        end
                    end else begin
                        n_m = r_m + 4'd1;
                        if (r_d > gda_pkg::month_len(r_y, r_m + 4'd1)) begin
                            n_d = gda_pkg::month_len(r_y, r_m + 4'd1);
                        end
                    end
                end else begin
                    if (r_y >= MaxY) begin
                        n_y = MaxY;
                        n_m = 4'd12;
                        n_d = 5'd31;
                    end else begin
                        n_y = r_y + 16'd1;
                        if (r_d > gda_pkg::month_len(r_y + 16'd1, r_m)) begin
                            n_d = gda_pkg::month_len(r_y + 16'd1, r_m);
                        end
                    end
                end
                n_state = gda_pkg::S_DONE;
            end
            gda_pkg::S_DONE: begin
                // load the output register once it is free
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_oy      = c_has_date ? r_y[13:0] : 14'd0;
                    n_om      = c_has_date ? r_m : 4'd0;
                    n_od      = c_has_date ? r_d : 5'd0;
                    n_oc      = (r_func == gda_pkg::FN_DAY_COUNT) ? r_count : 23'd0;
                    n_ow      = (r_func == gda_pkg::FN_WEEKDAY) ? r_wd : 3'd0;
                    n_state   = gda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gda_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gda_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_func <= i_func;
            r_ya   <= i_year_a;
            r_ma   <= i_month_a;
            r_da   <= i_day_a;
            r_yb   <= i_year_b;
            r_mb   <= i_month_b;
            r_db   <= i_day_b;
        end
        r_y      <= n_y;
        r_m      <= n_m;
        r_d      <= n_d;
        r_i      <= n_i;
        r_cnt    <= n_cnt;
        r_second <= n_second;
        r_acc    <= n_acc;
        r_ser_a  <= n_ser_a;
        r_count  <= n_count;
        r_wd     <= n_wd;
        r_oy     <= n_oy;
        r_om     <= n_om;
        r_od     <= n_od;
        r_oc     <= n_oc;
        r_ow     <= n_ow;
    end

    assign o_valid     = r_o_valid;
    assign o_res_year  = r_oy;
    assign o_res_month = r_om;
    assign o_res_day   = r_od;
    assign o_day_count = $signed(r_oc);
    assign o_weekday   = r_ow;

    // an accepted request always starts with the clamp cycle
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_accept |=> (r_state == gda_pkg::S_LOAD))
        else $error("request accepted without entering load");

    // day stepping never runs with an empty count
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gda_pkg::S_STEP) |-> (r_cnt != 3'd0))
        else $error("day step with zero count");

    // month walk never passes the target month
    a_month_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gda_pkg::S_MON) |-> (r_i <= r_m))
        else $error("month walk overran");

    // a result month is zero or a real month
    a_res_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res_month <= 4'd12))
        else $error("result month out of range");

endmodule
